// ----- rtl/core/lbi_pkg.sv -----
// lbi_pkg: shared types and constants of the breakpoint interpolator
// transfer payload structs, breakpoint entry, arithmetic request, status codes
// no dependencies
package lbi_pkg;

  // field widths
  localparam int unsigned PosW   = 14;
  localparam int unsigned WidthW = 8;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned CycW   = 16;

  // parameter defaults
  localparam int unsigned ChannelsDef = 16;
  localparam int unsigned PointsDef   = 8;

  // cycle limit after reset
  localparam logic [PosW-1:0] LimitReset = 14'd10000;

  // item modes
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeEval  = 1'b1;

  // lookup status codes
  localparam logic [1:0] StInterp = 2'd0;
  localparam logic [1:0] StExact  = 2'd1;
  localparam logic [1:0] StBelow  = 2'd2;
  localparam logic [1:0] StBeyond = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [ChanW-1:0]  channel;
    logic [SlotW-1:0]  point_index;
    logic [PosW-1:0]   breakpoint_position;
    logic [WidthW-1:0] breakpoint_width;
    logic [CycW-1:0]   cycle_position;
  } in_item_t;

  typedef struct packed {
    logic [WidthW-1:0] pulse_width;
    logic [1:0]        lookup_status;
  } out_item_t;

  // one stored breakpoint
  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [WidthW-1:0] width;
  } entry_t;

  // operands handed to the serial multiply/divide unit
  typedef struct packed {
    logic [WidthW-1:0] lo_width;
    logic [WidthW-1:0] hi_width;
    logic [PosW-1:0]   offset;
    logic [PosW-1:0]   span;
  } arith_req_t;

endpackage

// ----- rtl/core/lbi_ram.sv -----
// lbi_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module lbi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lbi_arith.sv -----
// lbi_arith: bit-serial multiply then restoring divide with half-up rounding
// computes lo +/- round(|hi-lo| * offset / span), one bit per cycle
// depends on lbi_pkg
module lbi_arith
  import lbi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  arith_req_t        req_i,
  output logic              done_o,
  output logic [WidthW-1:0] width_o
);

  localparam int unsigned MagW = WidthW + PosW;   // product width
  localparam int unsigned NumW = MagW + 2;        // 2*mag + span
  localparam int unsigned CntW = $clog2(WidthW);

  localparam logic [1:0] AIdle = 2'd0;
  localparam logic [1:0] AMul  = 2'd1;
  localparam logic [1:0] ADiv  = 2'd2;
  localparam logic [1:0] ADone = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              up_q, up_d;
  logic [WidthW-1:0] lo_q, lo_d;
  logic [WidthW-1:0] dmag_q, dmag_d;
  logic [PosW-1:0]   span_q, span_d;
  logic [MagW-1:0]   mcand_q, mcand_d;
  logic [MagW-1:0]   acc_q, acc_d;
  logic [NumW-1:0]   rem_q, rem_d;
  logic [MagW-1:0]   dsr_q, dsr_d;
  logic [WidthW-1:0] quo_q, quo_d;
  logic [MagW-1:0]   acc_sum;
  logic              fits;
  logic              last_digit;

  assign acc_sum    = dmag_q[0] ? acc_q + mcand_q : acc_q;
  assign fits       = rem_q >= {2'b00, dsr_q};
  assign last_digit = cnt_q == CntW'(WidthW - 1);

  // sequencer: start, eight multiply steps, eight divide steps, done
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    up_d    = up_q;
    lo_d    = lo_q;
    dmag_d  = dmag_q;
    span_d  = span_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    unique case (phase_q)
      AIdle: begin
        if (start_i) begin
          up_d    = req_i.hi_width >= req_i.lo_width;
          dmag_d  = up_d ? req_i.hi_width - req_i.lo_width
                         : req_i.lo_width - req_i.hi_width;
          lo_d    = req_i.lo_width;
          span_d  = req_i.span;
          mcand_d = {{WidthW{1'b0}}, req_i.offset};
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = AMul;
        end
      end
      AMul: begin
        acc_d   = acc_sum;
        mcand_d = {mcand_q[MagW-2:0], 1'b0};
        dmag_d  = {1'b0, dmag_q[WidthW-1:1]};
        cnt_d   = cnt_q + 1'b1;
        if (last_digit) begin
          // numerator 2*mag + span, divisor 2*span aligned to the top quotient bit
          rem_d   = {1'b0, acc_sum, 1'b0} + {{(NumW-PosW){1'b0}}, span_q};
          dsr_d   = {span_q, {(MagW-PosW){1'b0}}};
          quo_d   = '0;
          cnt_d   = '0;
          phase_d = ADiv;
        end
      end
      ADiv: begin
        if (fits) begin
          rem_d = rem_q - {2'b00, dsr_q};
        end
        quo_d = {quo_q[WidthW-2:0], fits};
        dsr_d = {1'b0, dsr_q[MagW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (last_digit) begin
          phase_d = ADone;
        end
      end
      ADone: begin
        phase_d = AIdle;
      end
      default: phase_d = AIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= AIdle;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    up_q    <= up_d;
    lo_q    <= lo_d;
    dmag_q  <= dmag_d;
    span_q  <= span_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    dsr_q   <= dsr_d;
    quo_q   <= quo_d;
  end

  assign done_o  = phase_q == ADone;
  assign width_o = up_q ? lo_q + quo_q : lo_q - quo_q;

endmodule

// ----- rtl/core/lut_breakpoint_interpolator.sv -----
// lut_breakpoint_interpolator: per-channel breakpoint table with linear interpolation
// depends on lbi_pkg, lbi_ram, lbi_arith
//
//   port group   direction  handshake            payload
//   in           input      in_valid_i/in_stall_o  in_item_t  (write or evaluate)
//   out          output     out_valid_o/out_stall_i out_item_t (one per evaluate)
//   cfg          input      cfg_we_i              cfg_wdata_i (cycle limit)
//
// a write item gives no result
// an evaluate scans one slot per cycle from the ram read port, up to Points slots;
// an exact, below or beyond result passes through SEmit to the output register
// an interpolated result waits in SArith for the lbi_arith multiply, divide and
// done steps, then passes through SEmit to the output register as well
// reset clears control state only; table entries hold garbage until written
// a finished result waits in the output register while the next item is taken
module lut_breakpoint_interpolator
  import lbi_pkg::*;
#(
  parameter int unsigned Channels = ChannelsDef,
  parameter int unsigned Points   = PointsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [PosW-1:0] cfg_wdata_i
);

  localparam int unsigned Depth = Channels * Points;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW  = $clog2(Points);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Points - 1);

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SScan  = 2'd1;
  localparam logic [1:0] SArith = 2'd2;
  localparam logic [1:0] SEmit  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PosW-1:0]   limit_q;
  logic [ChanW-1:0]  ch_q, ch_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  entry_t            lo_q, lo_d;
  logic [WidthW-1:0] res_w_q, res_w_d;
  logic [1:0]        res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              in_xfer, ch_ok, slot_ok, wr_en, ev_start;
  logic [PosW-1:0]   pos_clamp;
  logic [AddrW-1:0]  waddr, raddr;
  entry_t            wentry, rd;
  logic              hit_eq, hit_lt, arith_start, arith_done, out_load;
  arith_req_t        arith_req;
  logic [WidthW-1:0] arith_width;

  // input transfer and decode
  assign in_stall_o = state_q != SIdle;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ch_ok      = int'(in_data_i.channel) < Channels;
  assign slot_ok    = int'(in_data_i.point_index) < Points;
  assign wr_en      = in_xfer && (in_data_i.mode == ModeWrite) && ch_ok && slot_ok;
  assign ev_start   = in_xfer && (in_data_i.mode == ModeEval) && ch_ok;
  assign pos_clamp  = (in_data_i.cycle_position > {2'b00, limit_q}) ? limit_q
                      : in_data_i.cycle_position[PosW-1:0];

  assign waddr  = AddrW'(int'(in_data_i.channel) * Points + int'(in_data_i.point_index));
  assign wentry = '{pos: in_data_i.breakpoint_position, width: in_data_i.breakpoint_width};

  // read address: slot 0 on start, then one slot ahead of the compare
  always_comb begin
    if (state_q == SScan && idx_q != LastIdx) begin
      raddr = AddrW'(int'(ch_q) * Points + int'(idx_q) + 1);
    end else if (state_q == SScan) begin
      raddr = AddrW'(int'(ch_q) * Points + int'(idx_q));
    end else begin
      raddr = AddrW'(int'(in_data_i.channel) * Points);
    end
  end

  lbi_ram #(
    .Width ($bits(entry_t)),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  // slot compare
  assign hit_eq      = pos_q == rd.pos;
  assign hit_lt      = pos_q < rd.pos;
  assign arith_start = (state_q == SScan) && !hit_eq && hit_lt && (idx_q != '0);
  assign arith_req   = '{lo_width: lo_q.width, hi_width: rd.width,
                         offset: pos_q - lo_q.pos, span: rd.pos - lo_q.pos};

  lbi_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (arith_start),
    .req_i   (arith_req),
    .done_o  (arith_done),
    .width_o (arith_width)
  );

  assign out_load = (state_q == SEmit) && (!out_valid_q || !out_stall_i);

  // scan sequencer
  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    lo_d     = lo_q;
    res_w_d  = res_w_q;
    res_st_d = res_st_q;
    unique case (state_q)
      SIdle: begin
        if (ev_start) begin
          ch_d    = in_data_i.channel;
          pos_d   = pos_clamp;
          idx_d   = '0;
          state_d = SScan;
        end
      end
      SScan: begin
        lo_d  = rd;
        idx_d = idx_q + 1'b1;
        if (hit_eq) begin
          res_w_d  = rd.width;
          res_st_d = StExact;
          state_d  = SEmit;
        end else if (hit_lt && idx_q == '0) begin
          res_w_d  = rd.width;
          res_st_d = StBelow;
          state_d  = SEmit;
        end else if (hit_lt) begin
          res_st_d = StInterp;
          state_d  = SArith;
        end else if (idx_q == LastIdx) begin
          res_w_d  = rd.width;
          res_st_d = StBeyond;
          state_d  = SEmit;
        end
      end
      SArith: begin
        if (arith_done) begin
          res_w_d = arith_width;
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = '{pulse_width: res_w_q, lookup_status: res_st_q};
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      limit_q     <= LimitReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    lo_q     <= lo_d;
    res_w_q  <= res_w_d;
    res_st_q <= res_st_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_done_in_arith: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_done |-> state_q == SArith)
    else $error("arithmetic done outside the interpolation wait");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled transfer");

  a_eval_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_start |=> state_q == SScan && idx_q == '0)
    else $error("evaluate transfer did not start the scan at slot 0");

  a_start_only_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_start |=> state_q == SArith)
    else $error("interpolation started without entering the wait");

endmodule

// ----- dv/lut_breakpoint_interpolator_tb.sv -----
// lut_breakpoint_interpolator_tb: self-checking testbench of the breakpoint interpolator
// holds a pulse width scoreboard class, driver tasks and directed plus random stimulus
// depends on lbi_pkg and lut_breakpoint_interpolator
module lut_breakpoint_interpolator_tb;
  import lbi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let the block settle once no result is pending
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned MaxWait      = 12;

  // tracks the breakpoint tables and predicts each pulse width
  class pulse_width_scoreboard;
    logic [PosW-1:0]   bp_pos   [ChannelsDef][PointsDef];
    logic [WidthW-1:0] bp_width [ChannelsDef][PointsDef];
    logic [PosW-1:0]   cycle_limit;
    out_item_t         expected_widths[$];
    int unsigned       mismatches;

    function new();
      cycle_limit = LimitReset;
      mismatches  = 0;
    endfunction

    function void set_limit(logic [PosW-1:0] value);
      cycle_limit = value;
    endfunction

    // clamp, scan the channel's slots from 0 up, then match or interpolate
    function out_item_t lookup_width(logic [ChanW-1:0] ch, logic [CycW-1:0] cyc);
      int unsigned pos, lo_p, hi_p, lo_w, hi_w, diff, q;
      bit          found;
      out_item_t   r;
      pos = cyc;
      if (pos > cycle_limit) pos = cycle_limit;
      r.pulse_width   = bp_width[ch][PointsDef-1];
      r.lookup_status = StBeyond;
      found = 1'b0;
      for (int j = 0; j < PointsDef; j++) begin
        hi_p = bp_pos[ch][j];
        if (!found && pos == hi_p) begin
          found           = 1'b1;
          r.pulse_width   = bp_width[ch][j];
          r.lookup_status = StExact;
        end else if (!found && pos < hi_p) begin
          found = 1'b1;
          if (j == 0) begin
            r.pulse_width   = bp_width[ch][0];
            r.lookup_status = StBelow;
          end else begin
            lo_p = bp_pos[ch][j-1];
            lo_w = bp_width[ch][j-1];
            hi_w = bp_width[ch][j];
            diff = (hi_w >= lo_w) ? hi_w - lo_w : lo_w - hi_w;
            // magnitude rounded half away from zero, sign applied after
            q = (2 * diff * (pos - lo_p) + (hi_p - lo_p)) / (2 * (hi_p - lo_p));
            r.pulse_width   = WidthW'((hi_w >= lo_w) ? lo_w + q : lo_w - q);
            r.lookup_status = StInterp;
          end
        end
      end
      return r;
    endfunction

    // accepted input transfer: update a table or queue a prediction
    function void note_input(in_item_t it);
      if (it.mode == ModeWrite) begin
        bp_pos[it.channel][it.point_index]   = it.breakpoint_position;
        bp_width[it.channel][it.point_index] = it.breakpoint_width;
      end else begin
        expected_widths.push_back(lookup_width(it.channel, it.cycle_position));
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MaxReported) $display("%0t ns: %s", $time, msg);
    endfunction

    // accepted output transfer: compare with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_widths.size() == 0) begin
        flag($sformatf("result with none pending: width %0d status %0d",
                       got.pulse_width, got.lookup_status));
      end else begin
        want = expected_widths.pop_front();
        if (got.pulse_width !== want.pulse_width)
          flag($sformatf("pulse_width expected %0d got %0d",
                         want.pulse_width, got.pulse_width));
        if (got.lookup_status !== want.lookup_status)
          flag($sformatf("lookup_status expected %0d got %0d",
                         want.lookup_status, got.lookup_status));
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  out_item_t       out_data_o;
  logic            cfg_we_i;
  logic [PosW-1:0] cfg_wdata_i;

  pulse_width_scoreboard sb;
  bit                    sender_calm;
  bit                    receiver_calm;
  bit [PointsDef-1:0]    slots_loaded [ChannelsDef];
  int unsigned           items_sent;

  lut_breakpoint_interpolator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // result sink: random stall before each transfer, calm stretches in between
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) receiver_calm = !receiver_calm;
      hold = receiver_calm ? 0 : $urandom_range(0, MaxWait);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  function automatic in_item_t make_item(logic mode, int unsigned ch, int unsigned slot,
                                         int unsigned bpos, int unsigned bwidth,
                                         int unsigned cyc);
    in_item_t it;
    it.mode                = mode;
    it.channel             = ChanW'(ch);
    it.point_index         = SlotW'(slot);
    it.breakpoint_position = PosW'(bpos);
    it.breakpoint_width    = WidthW'(bwidth);
    it.cycle_position      = CycW'(cyc);
    return it;
  endfunction

  // one input transfer with a random lead gap; valid stays up between back-to-back items
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, MaxWait);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    if (it.mode == ModeWrite) slots_loaded[it.channel][it.point_index] = 1'b1;
    items_sent++;
  endtask

  task automatic write_entry(input int unsigned ch, input int unsigned slot,
                             input int unsigned bpos, input int unsigned bwidth);
    send_item(make_item(ModeWrite, ch, slot, bpos, bwidth, $urandom_range(0, 65535)));
  endtask

  task automatic evaluate(input int unsigned ch, input int unsigned cyc);
    send_item(make_item(ModeEval, ch, $urandom_range(0, PointsDef - 1),
                        $urandom_range(0, 16383), $urandom_range(0, 255), cyc));
  endtask

  // stop sending, wait for every pending result, then let the block go idle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_widths.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_cycle_limit(input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= PosW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_limit(PosW'(value));
  endtask

  // full table: tight, medium or wide ascending steps, sometimes scrambled
  task automatic load_table(input int unsigned ch);
    int unsigned style, step_max, p;
    style    = $urandom_range(0, 9);
    step_max = (style < 3) ? 4 : (style < 7) ? 300 : 2400;
    p        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 12000);
    for (int s = 0; s < PointsDef; s++) begin
      if (style == 9) p = $urandom_range(0, 16383);
      else if (s > 0) p = p + $urandom_range(0, step_max);
      if (p > 16383) p = 16383;
      write_entry(ch, s, p, $urandom_range(0, 255));
    end
  endtask

  function automatic int pick_loaded_channel();
    int unsigned start;
    start = $urandom_range(0, ChannelsDef - 1);
    for (int k = 0; k < ChannelsDef; k++)
      if (&slots_loaded[(start + k) % ChannelsDef]) return (start + k) % ChannelsDef;
    return -1;
  endfunction

  // evaluate near a stored breakpoint, between two, below, beyond, or anywhere
  task automatic evaluate_random(input int unsigned ch);
    int unsigned j, a, b, cyc;
    j = $urandom_range(0, PointsDef - 1);
    a = sb.bp_pos[ch][j];
    b = sb.bp_pos[ch][(j + 1) % PointsDef];
    case ($urandom_range(0, 9))
      0, 1, 2: cyc = a;
      3, 4, 5: cyc = (a < b) ? $urandom_range(b, a) : $urandom_range(a, b);
      6:       cyc = $urandom_range(0, sb.bp_pos[ch][0]);
      7:       cyc = $urandom_range(sb.bp_pos[ch][PointsDef-1], 65535);
      default: cyc = $urandom_range(0, 65535);
    endcase
    evaluate(ch, cyc);
  endtask

  task automatic run_phase(input int unsigned n_items, input bit pause_mid);
    int unsigned stop_at, roll;
    int          ch;
    bit          paused;
    stop_at = items_sent + n_items;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      if (pause_mid && !paused && items_sent + n_items / 2 >= stop_at) begin
        drain_results();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      ch   = pick_loaded_channel();
      if (ch < 0 || roll < 7)
        load_table($urandom_range(0, ChannelsDef - 1));
      else if (roll < 17)
        write_entry($urandom_range(0, ChannelsDef - 1), $urandom_range(0, PointsDef - 1),
                    $urandom_range(0, 16383), $urandom_range(0, 255));
      else
        evaluate_random(ch);
    end
  endtask

  // main sequence
  initial begin : stimulus
    int unsigned sorted_pos [PointsDef];
    int unsigned sorted_w   [PointsDef];
    int unsigned mixed_pos  [PointsDef];
    int unsigned mixed_w    [PointsDef];
    int unsigned phase_limit [6];
    int unsigned phase_len   [6];
    sorted_pos  = '{100, 500, 1000, 2000, 4000, 6000, 9000, 12000};
    sorted_w    = '{10, 255, 0, 128, 128, 200, 50, 255};
    mixed_pos   = '{0, 8000, 20, 16383, 3, 16383, 9000, 12};
    mixed_w     = '{255, 0, 200, 17, 128, 255, 1, 0};
    phase_limit = '{16383, $urandom_range(1, 16383), 1, $urandom_range(1, 16383),
                    10000, $urandom_range(1, 16383)};
    phase_len   = '{200, 200, 60, 200, 200, 200};

    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    items_sent    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: a sorted table on the first channel, an unsorted one on the last
    for (int s = 0; s < PointsDef; s++) begin
      write_entry(0, s, sorted_pos[s], sorted_w[s]);
      write_entry(ChannelsDef - 1, s, mixed_pos[s], mixed_w[s]);
    end
    // reset limit: below first, exact, rising and falling spans, clamp into a span
    evaluate(0, 50);
    evaluate(0, 0);
    evaluate(0, 100);
    evaluate(0, 300);
    evaluate(0, 500);
    evaluate(0, 750);
    evaluate(0, 3000);
    evaluate(0, 65535);
    evaluate(ChannelsDef - 1, 0);
    evaluate(ChannelsDef - 1, 5000);
    evaluate(ChannelsDef - 1, 8000);
    evaluate(ChannelsDef - 1, 10000);
    drain_results();

    // widest limit: beyond the last point, exact at the top
    set_cycle_limit(16383);
    evaluate(0, 65535);
    evaluate(0, 16383);
    evaluate(ChannelsDef - 1, 16383);
    evaluate(ChannelsDef - 1, 40000);
    drain_results();

    // zero limit: everything clamps to position 0
    set_cycle_limit(0);
    evaluate(0, 12345);
    evaluate(ChannelsDef - 1, 65535);
    drain_results();

    // random phases, one limit each
    for (int ph = 0; ph < 6; ph++) begin
      set_cycle_limit(phase_limit[ph]);
      run_phase(phase_len[ph], ph == 1);
      drain_results();
    end

    if (sb.mismatches == 0 && sb.expected_widths.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
